// ----- src/tga_pkg.sv -----
// Shared types and constants for the uncompressed truecolor TGA pixel decoder.
// Holds the input and result transfer structs and the header field offsets.
// No dependencies.
package tga_pkg;

    localparam int unsigned HEADER_LEN = 18;

    // Header byte offsets (16-bit fields are little-endian)
    localparam logic [4:0] HDR_ID_LENGTH   = 5'd0;
    localparam logic [4:0] HDR_CMAP_KIND   = 5'd1;
    localparam logic [4:0] HDR_IMAGE_KIND  = 5'd2;
    localparam logic [4:0] HDR_CMAP_LEN_LO = 5'd5;
    localparam logic [4:0] HDR_CMAP_LEN_HI = 5'd6;
    localparam logic [4:0] HDR_CMAP_BITS   = 5'd7;
    localparam logic [4:0] HDR_WIDTH_LO    = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI    = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO   = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI   = 5'd15;
    localparam logic [4:0] HDR_DEPTH       = 5'd16;
    localparam logic [4:0] HDR_LAST        = 5'(HEADER_LEN - 1);

    localparam logic [7:0] DEPTH_24        = 8'd24;
    localparam logic [7:0] DEPTH_32        = 8'd32;
    localparam logic [7:0] KIND_TRUECOLOR  = 8'd2;
    localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [31:0] pixel_color;
        logic        last_pixel;
        logic        unsupported_type;
    } t_out_item;

endpackage

// ----- src/tga_uncompressed_pixel_decoder_unit.sv -----
// Top level of the uncompressed truecolor TGA pixel decoder.
// Depends on tga_pkg for the transfer structs and header constants.
//
// A pixel result is registered into the output register on the transfer of its
//   final byte, or parked in the skid stage when the output register is full and stalled.
// Throughput: one byte per cycle while o_in_stall is low. o_in_stall rises only when a
//   result sits in the skid stage because the output register is full and stalled; it drops once that result moves on.
// Reset (i_rst_n low, synchronous): header capture from byte 0, all captured
//   header fields and pixel counters cleared, output and skid stages empty.
module tga_uncompressed_pixel_decoder_unit
    import tga_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    // Decoder state
    t_phase      r_phase,      n_phase;
    logic [4:0]  r_hdr_idx,    n_hdr_idx;
    logic [7:0]  r_id_len,     n_id_len;
    logic [7:0]  r_cmap_kind,  n_cmap_kind;
    logic [15:0] r_cmap_len,   n_cmap_len;
    logic [7:0]  r_cmap_bits,  n_cmap_bits;
    logic [7:0]  r_img_kind,   n_img_kind;
    logic [15:0] r_width,      n_width;
    logic [15:0] r_height,     n_height;
    logic [7:0]  r_depth,      n_depth;
    logic [23:0] r_skip,       n_skip;
    logic [1:0]  r_pix_idx,    n_pix_idx;
    logic [23:0] r_accum,      n_accum;
    logic [15:0] r_col,        n_col;
    logic [15:0] r_row,        n_row;

    // Output register and skid stage
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic        r_skid_valid;
    t_out_item   r_skid_item;

    logic        w_accept;
    logic        w_res_valid;
    t_out_item   w_res;

    // Never take a byte while the skid stage is holding a result.
    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        logic        first;
        logic [7:0]  b;
        t_phase      e_phase;
        logic [4:0]  e_hdr_idx;
        logic [5:0]  entry_bytes;
        logic [21:0] cmap_bytes;
        logic [23:0] skip_total;
        logic        pixels_ok;
        logic [2:0]  next_idx;
        logic [2:0]  nbytes;
        logic [23:0] color24;
        logic [16:0] col_inc;
        logic [16:0] row_inc;
        logic        last;

        first = w_accept && i_in_item.first_byte;
        b     = i_in_item.data_byte;

        // A transferred first byte restarts the image: act on cleared state.
        e_phase   = first ? PH_HEADER : r_phase;
        e_hdr_idx = first ? 5'd0 : r_hdr_idx;
        n_phase     = e_phase;
        n_hdr_idx   = e_hdr_idx;
        n_id_len    = first ? 8'd0  : r_id_len;
        n_cmap_kind = first ? 8'd0  : r_cmap_kind;
        n_cmap_len  = first ? 16'd0 : r_cmap_len;
        n_cmap_bits = first ? 8'd0  : r_cmap_bits;
        n_img_kind  = first ? 8'd0  : r_img_kind;
        n_width     = first ? 16'd0 : r_width;
        n_height    = first ? 16'd0 : r_height;
        n_depth     = first ? 8'd0  : r_depth;
        n_skip      = first ? 24'd0 : r_skip;
        n_pix_idx   = first ? 2'd0  : r_pix_idx;
        n_accum     = first ? 24'd0 : r_accum;
        n_col       = first ? 16'd0 : r_col;
        n_row       = first ? 16'd0 : r_row;

        entry_bytes = 6'(({1'b0, n_cmap_bits} + 9'd7) >> 3);
        cmap_bytes  = n_cmap_len * entry_bytes;
        skip_total  = 24'(n_id_len) + ((n_cmap_kind != 8'd0) ? 24'(cmap_bytes) : 24'd0);
        pixels_ok   = ((n_depth == DEPTH_24) || (n_depth == DEPTH_32))
                      && (n_width != 16'd0) && (n_height != 16'd0);

        next_idx = 3'(r_pix_idx) + 3'd1;
        nbytes   = (r_depth == DEPTH_32) ? 3'd4 : 3'd3;
        color24  = r_accum;
        case (r_pix_idx)
            2'd0:    color24[7:0]   = b;
            2'd1:    color24[15:8]  = b;
            2'd2:    color24[23:16] = b;
            default: color24 = r_accum;   // alpha byte: drop
        endcase
        col_inc = {1'b0, r_col} + 17'd1;
        row_inc = {1'b0, r_row} + 17'd1;
        last    = (col_inc == {1'b0, r_width}) && (row_inc == {1'b0, r_height});

        w_res_valid = 1'b0;
        w_res.pixel_x          = r_col;
        w_res.pixel_y          = r_row;
        w_res.pixel_color      = {(r_depth == DEPTH_32) ? ALPHA_OPAQUE : 8'd0, color24};
        w_res.last_pixel       = last;
        w_res.unsupported_type = (r_img_kind != KIND_TRUECOLOR);

        if (w_accept) begin
            case (e_phase)
                PH_HEADER: begin
                    case (e_hdr_idx)
                        HDR_ID_LENGTH:   n_id_len          = b;
                        HDR_CMAP_KIND:   n_cmap_kind       = b;
                        HDR_IMAGE_KIND:  n_img_kind        = b;
                        HDR_CMAP_LEN_LO: n_cmap_len[7:0]   = b;
                        HDR_CMAP_LEN_HI: n_cmap_len[15:8]  = b;
                        HDR_CMAP_BITS:   n_cmap_bits       = b;
                        HDR_WIDTH_LO:    n_width[7:0]      = b;
                        HDR_WIDTH_HI:    n_width[15:8]     = b;
                        HDR_HEIGHT_LO:   n_height[7:0]     = b;
                        HDR_HEIGHT_HI:   n_height[15:8]    = b;
                        HDR_DEPTH:       n_depth           = b;
                        default:         n_depth           = n_depth;
                    endcase
                    n_hdr_idx = e_hdr_idx + 5'd1;
                    if (e_hdr_idx == HDR_LAST) begin
                        n_hdr_idx = 5'd0;
                        n_skip    = skip_total;
                        if (skip_total != 24'd0) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = pixels_ok ? PH_PIXELS : PH_DONE;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 24'd1;
                    if (n_skip == 24'd0) begin
                        n_phase = pixels_ok ? PH_PIXELS : PH_DONE;
                    end
                end
                PH_PIXELS: begin
                    if (next_idx < nbytes) begin
                        n_pix_idx = next_idx[1:0];
                        n_accum   = color24;
                    end else begin
                        n_pix_idx   = 2'd0;
                        n_accum     = 24'd0;
                        w_res_valid = 1'b1;
                        if (last) begin
                            n_phase = PH_DONE;
                        end else if (col_inc >= {1'b0, r_width}) begin
                            n_col = 16'd0;
                            n_row = row_inc[15:0];
                        end else begin
                            n_col = col_inc[15:0];
                        end
                    end
                end
                default: n_phase = e_phase;   // done: drop bytes until restart
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_idx    <= '0;
            r_id_len     <= '0;
            r_cmap_kind  <= '0;
            r_cmap_len   <= '0;
            r_cmap_bits  <= '0;
            r_img_kind   <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_depth      <= '0;
            r_skip       <= '0;
            r_pix_idx    <= '0;
            r_accum      <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_id_len    <= n_id_len;
            r_cmap_kind <= n_cmap_kind;
            r_cmap_len  <= n_cmap_len;
            r_cmap_bits <= n_cmap_bits;
            r_img_kind  <= n_img_kind;
            r_width     <= n_width;
            r_height    <= n_height;
            r_depth     <= n_depth;
            r_skip      <= n_skip;
            r_pix_idx   <= n_pix_idx;
            r_accum     <= n_accum;
            r_col       <= n_col;
            r_row       <= n_row;

            if (!r_out_valid || !i_out_stall) begin
                // Output register free: refill from skid first, else from new result.
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_item   <= r_skid_item;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept && w_res_valid;
                    r_out_item  <= w_res;
                end
            end else if (w_accept && w_res_valid) begin
                // Output held by stall: park the new result.
                r_skid_valid <= 1'b1;
                r_skid_item  <= w_res;
            end
        end
    end

endmodule

// ----- tb/tga_uncompressed_pixel_decoder_unit_tb.sv -----
// Self-checking bench for the uncompressed truecolor TGA pixel decoder.
// Streams a directed file and random TGA files through the byte channel and checks each
// pixel transfer against an in-bench decoder; depends on tga_pkg and the decoder RTL.
module tga_uncompressed_pixel_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tga_pkg::*;

    localparam int unsigned RUN_BYTES    = 500;
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_PERCENT = 10;
    localparam int unsigned RESET_CYCLES = 8;
    // Byte counts that bound the idle-free stretch and the hold-off point
    localparam int unsigned STEADY_FROM  = 300;
    localparam int unsigned STEADY_TO    = 400;
    localparam int unsigned HOLD_AT      = 200;
    localparam int unsigned DIRECTED_LEN = 27;

    // Decoder progress through one file
    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_SKIP,
        DEC_PIXELS,
        DEC_DONE
    } t_dec_phase;

    // One row of the directed table: the byte, its restart flag, and an optional
    // pixel typed in by hand that replaces the predicted one
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       pinned;
        t_out_item  pixel;
    } t_dir_row;

    localparam t_out_item NO_PIXEL  = '0;
    // First pixel: all-zero colour bytes, alpha byte 0xFF is dropped, top byte forced
    localparam t_out_item PIX_BLACK = '{16'd0, 16'd0, 32'hFF00_0000, 1'b0, 1'b0};
    // Second and final pixel: all-ones colour bytes, alpha byte 0x00 is dropped
    localparam t_out_item PIX_WHITE = '{16'd1, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b0};

    logic      i_clk        = 1'b0;
    logic      i_rst_n      = 1'b0;
    logic      i_in_valid   = 1'b0;
    t_in_item  i_in_item    = '0;
    logic      i_out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Travel with each byte so the checker can swap in a hand-typed pixel
    logic      pinned_valid = 1'b0;
    t_out_item pinned_pixel = '0;

    // High while neither side may idle
    logic      steady       = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;

    // Pixels predicted for accepted bytes, oldest first
    t_out_item pending_pixels [$];

    // Decoder state mirrored in the bench
    t_dec_phase  dec_phase;
    logic [4:0]  hdr_pos;
    logic [7:0]  id_len;
    logic [7:0]  map_kind;
    logic [15:0] map_len;
    logic [7:0]  map_bits;
    logic [7:0]  img_kind;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  depth;
    logic [23:0] skip_left;
    logic [1:0]  px_byte;
    logic [23:0] rgb_acc;
    logic [15:0] col;
    logic [15:0] row;

    // Directed file: sent with no restart flag after reset, so capture must begin at
    // header byte 0 anyway. Colour map length and entry size are all ones but the map
    // kind is zero, so nothing may be skipped. 2x1 pixels at 32 bits, then one stray
    // byte after the last pixel that must be ignored.
    t_dir_row directed_bytes [DIRECTED_LEN] = '{
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},   // id length
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},   // colour map kind
        '{KIND_TRUECOLOR, 1'b0, 1'b0, NO_PIXEL},   // image kind
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},   // colour map length, low
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},   // colour map length, high
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},   // colour map entry bits
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},
        '{8'h02,          1'b0, 1'b0, NO_PIXEL},   // width, low
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},   // width, high
        '{8'h01,          1'b0, 1'b0, NO_PIXEL},   // height, low
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},   // height, high
        '{DEPTH_32,       1'b0, 1'b0, NO_PIXEL},
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},   // descriptor, ignored
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},   // pixel 0: blue
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},   //          green
        '{8'h00,          1'b0, 1'b0, NO_PIXEL},   //          red
        '{8'hFF,          1'b0, 1'b1, PIX_BLACK},  //          alpha
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},   // pixel 1: blue
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},   //          green
        '{8'hFF,          1'b0, 1'b0, NO_PIXEL},   //          red
        '{8'h00,          1'b0, 1'b1, PIX_WHITE},  //          alpha
        '{8'hA5,          1'b0, 1'b0, NO_PIXEL}    // past the last pixel
    };

    tga_uncompressed_pixel_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always #6 i_clk = ~i_clk;

    // Hard stop: ends a hung run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the result channel at random, except during the steady stretch
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic clear_decoder();
        hdr_pos   = '0;
        id_len    = '0;
        map_kind  = '0;
        map_len   = '0;
        map_bits  = '0;
        img_kind  = '0;
        img_w     = '0;
        img_h     = '0;
        depth     = '0;
        skip_left = '0;
        px_byte   = '0;
        rgb_acc   = '0;
        col       = '0;
        row       = '0;
    endtask

    // Pixels follow only for a 24 or 32 bit depth and a non-empty image
    function automatic t_dec_phase phase_after_skip();
        if ((depth == DEPTH_24 || depth == DEPTH_32) && img_w != 0 && img_h != 0)
            return DEC_PIXELS;
        return DEC_DONE;
    endfunction

    // Advance the mirrored decoder by one accepted byte; emitted flags a finished pixel
    task automatic decode_byte(input t_in_item item, output logic emitted,
                               output t_out_item pixel);
        int unsigned skip_total;
        int unsigned entry_bytes;
        int unsigned byte_pos;
        int unsigned pixel_bytes;
        logic        at_end;
        emitted = 1'b0;
        pixel   = '0;
        // A restart flag drops whatever image was in progress
        if (item.first_byte) begin
            dec_phase = DEC_HEADER;
            clear_decoder();
        end
        case (dec_phase)
            DEC_HEADER: begin
                case (hdr_pos)
                    HDR_ID_LENGTH:   id_len        = item.data_byte;
                    HDR_CMAP_KIND:   map_kind      = item.data_byte;
                    HDR_IMAGE_KIND:  img_kind      = item.data_byte;
                    HDR_CMAP_LEN_LO: map_len[7:0]  = item.data_byte;
                    HDR_CMAP_LEN_HI: map_len[15:8] = item.data_byte;
                    HDR_CMAP_BITS:   map_bits      = item.data_byte;
                    HDR_WIDTH_LO:    img_w[7:0]    = item.data_byte;
                    HDR_WIDTH_HI:    img_w[15:8]   = item.data_byte;
                    HDR_HEIGHT_LO:   img_h[7:0]    = item.data_byte;
                    HDR_HEIGHT_HI:   img_h[15:8]   = item.data_byte;
                    HDR_DEPTH:       depth         = item.data_byte;
                    default: ;
                endcase
                if (hdr_pos == HDR_LAST) begin
                    // Skip the id field, plus the colour map only when one is declared
                    skip_total = id_len;
                    if (map_kind != 0) begin
                        entry_bytes = (map_bits + 32'd7) >> 3;
                        skip_total += map_len * entry_bytes;
                    end
                    skip_left = skip_total[23:0];
                    hdr_pos   = '0;
                    dec_phase = (skip_left != 0) ? DEC_SKIP : phase_after_skip();
                end else begin
                    hdr_pos++;
                end
            end
            DEC_SKIP: begin
                skip_left--;
                if (skip_left == 0)
                    dec_phase = phase_after_skip();
            end
            DEC_PIXELS: begin
                pixel_bytes = (depth == DEPTH_32) ? 4 : 3;
                byte_pos    = px_byte;
                // Blue, green, red land in ascending bytes; a fourth byte is alpha, dropped
                if (byte_pos < 3)
                    rgb_acc = rgb_acc | (24'(item.data_byte) << (8 * byte_pos));
                byte_pos++;
                if (byte_pos < pixel_bytes) begin
                    px_byte = byte_pos[1:0];
                end else begin
                    px_byte = '0;
                    at_end  = (col + 32'd1 == img_w) && (row + 32'd1 == img_h);
                    emitted = 1'b1;
                    pixel.pixel_x          = col;
                    pixel.pixel_y          = row;
                    pixel.pixel_color      = {(depth == DEPTH_32) ? ALPHA_OPAQUE : 8'h00,
                                              rgb_acc};
                    pixel.last_pixel       = at_end;
                    pixel.unsupported_type = (img_kind != KIND_TRUECOLOR);
                    rgb_acc = '0;
                    if (at_end) begin
                        dec_phase = DEC_DONE;
                    end else if (col + 32'd1 >= img_w) begin
                        col = '0;
                        row++;
                    end else begin
                        col++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Check results against the oldest prediction, then predict for the byte
    // taken at this edge. Everything is sampled as it stood before the edge.
    always @(posedge i_clk) begin : check_pixels
        logic      emitted;
        t_out_item predicted;
        t_out_item wanted;
        if (!i_rst_n) begin
            dec_phase = DEC_HEADER;
            clear_decoder();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_pixels.size() == 0) begin
                    log_mismatch($sformatf("unexpected pixel x=%0d y=%0d colour=%h last=%b unsup=%b",
                                           o_out_item.pixel_x, o_out_item.pixel_y,
                                           o_out_item.pixel_color, o_out_item.last_pixel,
                                           o_out_item.unsupported_type));
                end else begin
                    wanted = pending_pixels.pop_front();
                    if (o_out_item.pixel_x          !== wanted.pixel_x     ||
                        o_out_item.pixel_y          !== wanted.pixel_y     ||
                        o_out_item.pixel_color      !== wanted.pixel_color ||
                        o_out_item.last_pixel       !== wanted.last_pixel  ||
                        o_out_item.unsupported_type !== wanted.unsupported_type)
                        log_mismatch($sformatf({"expected x=%0d y=%0d colour=%h last=%b ",
                                                "unsup=%b, got x=%0d y=%0d colour=%h ",
                                                "last=%b unsup=%b"},
                                               wanted.pixel_x, wanted.pixel_y,
                                               wanted.pixel_color, wanted.last_pixel,
                                               wanted.unsupported_type,
                                               o_out_item.pixel_x, o_out_item.pixel_y,
                                               o_out_item.pixel_color, o_out_item.last_pixel,
                                               o_out_item.unsupported_type));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_in_item, emitted, predicted);
                if (pinned_valid)
                    pending_pixels.push_back(pinned_pixel);
                else if (emitted)
                    pending_pixels.push_back(predicted);
            end
        end
    end

    // Offer one byte, idling beforehand at random; return at the edge of its transfer
    task automatic send_byte(input logic [7:0] value, input logic first,
                             input logic pinned, input t_out_item pixel);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_item    <= '{data_byte: value, first_byte: first};
        pinned_valid <= pinned;
        pinned_pixel <= pixel;
        // Hold the payload until the decoder takes it
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
        steady <= (bytes_sent >= STEADY_FROM) && (bytes_sent < STEADY_TO);
    endtask

    // Build one random file and stream it. Most files are well formed; the rest are
    // unusable headers, big images cut short by the next restart, or plain noise.
    task automatic send_file();
        logic [7:0]  hdr [HEADER_LEN];
        logic [7:0]  body [$];
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned body_len;
        logic [7:0]  depth_v;
        logic        noisy;
        logic        first;
        pick  = $urandom_range(99);
        noisy = 1'b0;
        foreach (hdr[i]) hdr[i] = 8'($urandom);
        if (pick < 60) begin
            // Small well-formed image, sometimes behind an id field and a colour map
            hdr[HDR_ID_LENGTH] = 8'($urandom_range(3));
            hdr[HDR_CMAP_KIND] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 1));
            if (hdr[HDR_CMAP_KIND] != 0) begin
                hdr[HDR_CMAP_LEN_LO] = 8'($urandom_range(3));
                hdr[HDR_CMAP_LEN_HI] = 8'h00;
                hdr[HDR_CMAP_BITS]   = 8'($urandom_range(40));
            end
            hdr[HDR_IMAGE_KIND] = ($urandom_range(4) == 0) ? 8'($urandom) : KIND_TRUECOLOR;
            w       = $urandom_range(5, 1);
            h       = $urandom_range(3, 1);
            depth_v = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
            body_len = hdr[HDR_ID_LENGTH] + w * h * (depth_v / 8) + $urandom_range(2);
            if (hdr[HDR_CMAP_KIND] != 0)
                body_len += hdr[HDR_CMAP_LEN_LO] * ((hdr[HDR_CMAP_BITS] + 32'd7) >> 3);
        end else if (pick < 70) begin
            // Unusable depth or an empty image: nothing may come out
            hdr[HDR_ID_LENGTH] = 8'($urandom_range(2));
            hdr[HDR_CMAP_KIND] = 8'h00;
            w       = $urandom_range(65535);
            h       = $urandom_range(65535);
            depth_v = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
            case ($urandom_range(2))
                0: begin
                    depth_v = 8'($urandom);
                    if (depth_v == DEPTH_24 || depth_v == DEPTH_32)
                        depth_v = 8'd16;
                end
                1: w = 0;
                default: h = 0;
            endcase
            body_len = $urandom_range(20);
        end else if (pick < 85) begin
            // Large image abandoned part way by the next file's restart
            hdr[HDR_ID_LENGTH] = 8'h00;
            hdr[HDR_CMAP_KIND] = 8'h00;
            w        = $urandom_range(65535, 1);
            h        = $urandom_range(65535, 1);
            depth_v  = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
            body_len = $urandom_range(40);
        end else begin
            // Noise: random header and stray restart flags anywhere
            noisy    = 1'b1;
            w        = {hdr[HDR_WIDTH_HI], hdr[HDR_WIDTH_LO]};
            h        = {hdr[HDR_HEIGHT_HI], hdr[HDR_HEIGHT_LO]};
            depth_v  = $urandom_range(1) ? hdr[HDR_DEPTH] : DEPTH_24;
            body_len = $urandom_range(40);
        end
        hdr[HDR_WIDTH_LO]  = w[7:0];
        hdr[HDR_WIDTH_HI]  = w[15:8];
        hdr[HDR_HEIGHT_LO] = h[7:0];
        hdr[HDR_HEIGHT_HI] = h[15:8];
        hdr[HDR_DEPTH]     = depth_v;
        repeat (body_len) body.push_back(8'($urandom));
        for (int i = 0; i < HEADER_LEN; i++) begin
            if (i == 0)
                first = noisy ? 1'($urandom_range(1)) : 1'b1;
            else
                first = noisy && ($urandom_range(99) < 5);
            send_byte(hdr[i], first, 1'b0, NO_PIXEL);
        end
        foreach (body[i])
            send_byte(body[i], noisy && ($urandom_range(99) < 5), 1'b0, NO_PIXEL);
    endtask

    initial begin : stimulus
        logic held;
        held = 1'b0;
        // Hold reset for a fixed count, then release it for good
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_byte(directed_bytes[i].data_byte, directed_bytes[i].first_byte,
                      directed_bytes[i].pinned, directed_bytes[i].pixel);

        // Random files until the byte budget is spent
        while (bytes_sent < RUN_BYTES) begin
            send_file();
            if (!held && bytes_sent >= HOLD_AT) begin
                // Drop valid and wait until every predicted pixel has drained
                held = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_pixels.size() != 0);
            end
        end

        // Drain: wait for the last pixels, then allow for the output latency
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
